### src/bfr_pkg.sv
package bfr_pkg;

    localparam int MAX_PACKAGE  = 1032;
    localparam int MAX_PAYLOAD  = 1024;
    localparam int HEADER_BYTES = 8;

    localparam logic [7:0] MAGIC0 = 8'hFE;
    localparam logic [7:0] MAGIC1 = 8'h01;

    // widths of the result fields and the internal counters
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 10;
    localparam int WORD_W   = 16;
    localparam int LEN_W    = 11;
    localparam int HPOS_W   = 4;

    // result queue depth and occupancy counter width
    localparam int QDEPTH  = 3;
    localparam int QCNT_W  = 2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [1:0] {
        STAT_COMPLETE   = 2'd0,
        STAT_INCOMPLETE = 2'd1,
        STAT_HDR_ERR    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RECV = 2'b10
    } rx_state_t;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   byte_value;
        logic [OFFSET_W-1:0] byte_offset;
        status_t             status;
        logic [WORD_W-1:0]   command;
        logic [WORD_W-1:0]   sequence_res;
        logic [LEN_W-1:0]    message_len;
        logic                last;
    } result_t;

endpackage

### src/bfr_in_if.sv
interface bfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frag_last;

    modport source (output valid, output data_byte, output frag_last, input ready);
    modport sink   (input valid, input data_byte, input frag_last, output ready);
endinterface

### src/bfr_out_if.sv
interface bfr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  byte_value;
    logic [9:0]  byte_offset;
    logic [1:0]  status;
    logic [15:0] command;
    logic [15:0] sequence_res;
    logic [10:0] message_len;
    logic        last;

    modport source (
        output valid, output kind, output byte_value, output byte_offset, output status,
        output command, output sequence_res, output message_len, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input byte_value, input byte_offset, input status,
        input command, input sequence_res, input message_len, input last,
        output ready
    );
endinterface

### src/ble_fragment_reassembler_unit.sv
// fragment reassembler: takes a link fragment stream, one byte per beat on frag,
// frag_last high on the final byte of each fragment. an idle fragment opens
// with the 8-byte header FE 01, length, command, sequence (all big-endian).
// res carries results: a payload beat (kind 0) with its offset in the message,
// and one status beat (kind 1) at every fragment end: complete, incomplete or
// header error. last marks the final result caused by one input beat.
// results of a beat are registered into the queue when taken; res shows its head.
// throughput: one input beat per cycle while res takes one beat per cycle; a
// beat with both a payload byte and a status needs two res beats. the results
// sit in a three-entry result queue, and frag.ready is high whenever at most
// one result is queued, so frag.ready never depends on res.ready in the same
// cycle.
// reset: async, active low; block returns to idle, header position cleared,
// result queue emptied. nothing needs clearing beyond that.
// res stall: queued results hold; once two are queued frag.ready drops and
// input beats wait until the receiver drains the queue.
module ble_fragment_reassembler_unit
    import bfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bfr_in_if.sink    frag,
    bfr_out_if.source res
);

    // reassembly state
    rx_state_t           state_reg, state_next;
    logic [HPOS_W-1:0]   header_pos_reg, header_pos_next;
    logic [WORD_W-1:0]   declared_len_reg, declared_len_next;
    logic [WORD_W-1:0]   command_reg, command_next;
    logic [WORD_W-1:0]   sequence_reg, sequence_next;
    logic [LEN_W-1:0]    stored_reg, stored_next;
    logic                frag_error_reg, frag_error_next;

    // result queue, entry 0 is the one on res
    result_t             slot_reg [QDEPTH];
    result_t             slot_next [QDEPTH];
    result_t             shifted [QDEPTH];
    logic [QCNT_W-1:0]   count_reg, count_next;

    logic                accept;
    logic                pop;
    logic [QCNT_W-1:0]   base;
    logic [QCNT_W-1:0]   n_new;
    logic                emit_pay;
    logic                emit_stat;
    status_t             stat_code;
    result_t             pay_res;
    result_t             stat_res;
    result_t             first_res;
    logic [WORD_W-1:0]   full_len;
    logic                complete_now;
    logic                complete_next;
    logic [7:0]          b;

    assign b          = frag.data_byte;
    assign frag.ready = ~count_reg[1];
    assign accept     = frag.valid & frag.ready;
    assign pop        = res.valid & res.ready;

    assign full_len   = {declared_len_reg[WORD_W-1:8], b};

    // message done once header plus stored payload covers the declared length
    assign complete_now  = !(({{(WORD_W-LEN_W){1'b0}}, stored_reg} + WORD_W'(HEADER_BYTES))
                             < declared_len_reg);
    assign complete_next = !(({{(WORD_W-LEN_W){1'b0}}, stored_next} + WORD_W'(HEADER_BYTES))
                             < declared_len_next);

    // per-beat reassembly step
    always_comb
    begin
        state_next        = state_reg;
        header_pos_next   = header_pos_reg;
        declared_len_next = declared_len_reg;
        command_next      = command_reg;
        sequence_next     = sequence_reg;
        stored_next       = stored_reg;
        frag_error_next   = frag_error_reg;
        emit_pay          = 1'b0;
        emit_stat         = 1'b0;
        stat_code         = STAT_HDR_ERR;

        case (state_reg)
            ST_IDLE:
            begin
                case (header_pos_reg)
                    4'd0:
                    begin
                        frag_error_next = (b != MAGIC0);
                        stored_next     = '0;
                    end
                    4'd1:
                    begin
                        if (b != MAGIC1)
                        begin
                            frag_error_next = 1'b1;
                        end
                    end
                    4'd2: declared_len_next = {b, 8'h00};
                    4'd3:
                    begin
                        // length clamp to the largest package
                        if (full_len > WORD_W'(MAX_PACKAGE))
                        begin
                            declared_len_next = WORD_W'(MAX_PACKAGE);
                        end
                        else
                        begin
                            declared_len_next = full_len;
                        end
                    end
                    4'd4: command_next  = {b, 8'h00};
                    4'd5: command_next  = {command_reg[WORD_W-1:8], b};
                    4'd6: sequence_next = {b, 8'h00};
                    4'd7: sequence_next = {sequence_reg[WORD_W-1:8], b};
                    default:
                    begin
                        if (!frag_error_reg && stored_reg < LEN_W'(MAX_PAYLOAD))
                        begin
                            emit_pay    = 1'b1;
                            stored_next = stored_reg + 1'b1;
                        end
                    end
                endcase
                if (header_pos_reg < HPOS_W'(HEADER_BYTES))
                begin
                    header_pos_next = header_pos_reg + 1'b1;
                end
                if (frag.frag_last)
                begin
                    emit_stat = 1'b1;
                    // short fragment or bad magic
                    if (frag_error_next || header_pos_reg < HPOS_W'(HEADER_BYTES - 1))
                    begin
                        stat_code = STAT_HDR_ERR;
                    end
                    else if (complete_next)
                    begin
                        stat_code = STAT_COMPLETE;
                    end
                    else
                    begin
                        stat_code  = STAT_INCOMPLETE;
                        state_next = ST_RECV;
                    end
                    header_pos_next = '0;
                    frag_error_next = 1'b0;
                end
            end
            ST_RECV:
            begin
                if (!complete_now && stored_reg < LEN_W'(MAX_PAYLOAD))
                begin
                    emit_pay    = 1'b1;
                    stored_next = stored_reg + 1'b1;
                end
                if (frag.frag_last)
                begin
                    emit_stat = 1'b1;
                    if (complete_next)
                    begin
                        stat_code  = STAT_COMPLETE;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        stat_code = STAT_INCOMPLETE;
                    end
                    header_pos_next = '0;
                    frag_error_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beats for this input
    always_comb
    begin
        pay_res              = '0;
        pay_res.kind         = KIND_PAYLOAD;
        pay_res.byte_value   = b;
        pay_res.byte_offset  = stored_reg[OFFSET_W-1:0];
        pay_res.status       = STAT_COMPLETE;
        pay_res.last         = ~emit_stat;

        stat_res             = '0;
        stat_res.kind        = KIND_STATUS;
        stat_res.status      = stat_code;
        if (stat_code == STAT_COMPLETE)
        begin
            stat_res.command      = command_next;
            stat_res.sequence_res = sequence_next;
        end
        if (stat_code != STAT_HDR_ERR)
        begin
            stat_res.message_len = stored_next;
        end
        stat_res.last        = 1'b1;

        first_res = emit_pay ? pay_res : stat_res;
        n_new     = QCNT_W'(emit_pay) + QCNT_W'(emit_stat);
    end

    // queue: shift out on pop, append new results behind what remains
    always_comb
    begin
        base = count_reg - QCNT_W'(pop);
        for (int i = 0; i < QDEPTH - 1; i++)
        begin
            shifted[i] = pop ? slot_reg[i+1] : slot_reg[i];
        end
        shifted[QDEPTH-1] = slot_reg[QDEPTH-1];

        for (int i = 0; i < QDEPTH; i++)
        begin
            slot_next[i] = shifted[i];
            if (accept && n_new != '0 && base == QCNT_W'(i))
            begin
                slot_next[i] = first_res;
            end
            if (accept && n_new == QCNT_W'(2) && QCNT_W'(base + 1'b1) == QCNT_W'(i))
            begin
                slot_next[i] = stat_res;
            end
        end
        count_next = accept ? base + n_new : base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            header_pos_reg   <= '0;
            declared_len_reg <= '0;
            command_reg      <= '0;
            sequence_reg     <= '0;
            stored_reg       <= '0;
            frag_error_reg   <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg        <= state_next;
                header_pos_reg   <= header_pos_next;
                declared_len_reg <= declared_len_next;
                command_reg      <= command_next;
                sequence_reg     <= sequence_next;
                stored_reg       <= stored_next;
                frag_error_reg   <= frag_error_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign res.valid        = (count_reg != '0);
    assign res.kind         = slot_reg[0].kind;
    assign res.byte_value   = slot_reg[0].byte_value;
    assign res.byte_offset  = slot_reg[0].byte_offset;
    assign res.status       = slot_reg[0].status;
    assign res.command      = slot_reg[0].command;
    assign res.sequence_res = slot_reg[0].sequence_res;
    assign res.message_len  = slot_reg[0].message_len;
    assign res.last         = slot_reg[0].last;

    // payload never runs past the buffer
    a_stored_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= LEN_W'(MAX_PAYLOAD))
        else $error("stored count beyond payload limit");

    // a continued message always has a clamped length
    a_len_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RECV |-> declared_len_reg <= WORD_W'(MAX_PACKAGE))
        else $error("declared length not clamped");

    // header position is cleared whenever a message is continued
    a_recv_hpos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RECV |-> header_pos_reg == '0)
        else $error("header position nonzero while receiving");

    // a non-final beat must have its status beat queued behind it
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.last |-> count_reg >= QCNT_W'(2) && slot_reg[1].kind == KIND_STATUS)
        else $error("payload beat without following status");

endmodule

### tb/ble_fragment_reassembler_unit_test.sv
module ble_fragment_reassembler_unit_test;
    import bfr_pkg::*;

    // run guard, far above the slowest legal run (about 900 beats with heavy stalls)
    localparam int CYCLE_LIMIT = 400000;
    // length of the one long receiver stall that backs the block up
    localparam int LONG_HOLD   = 300;

    // byte positions inside the 8-byte header
    localparam int POS_MAGIC0 = 0;
    localparam int POS_MAGIC1 = 1;
    localparam int POS_LEN_HI = 2;
    localparam int POS_LEN_LO = 3;
    localparam int POS_CMD_HI = 4;
    localparam int POS_CMD_LO = 5;
    localparam int POS_SEQ_HI = 6;
    localparam int POS_SEQ_LO = 7;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } link_byte_t;

    logic clk;
    logic rst_n;

    bfr_in_if  frag_bus ();
    bfr_out_if res_bus ();

    ble_fragment_reassembler_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .frag  (frag_bus),
        .res   (res_bus)
    );

    // link bytes waiting to be offered, and results the block still owes
    link_byte_t link_bytes[$];
    result_t    reassembly_out[$];

    int   send_idle_pct;
    int   recv_idle_pct;
    int   mismatches;
    int   cycle_count;
    int   queued_count;
    int   hold_left;
    logic hold_armed;

    // reassembly state as the block should hold it
    logic        in_message;
    logic [3:0]  hdr_pos;
    logic [15:0] decl_len;
    logic [15:0] cmd_word;
    logic [15:0] seq_word;
    logic [10:0] stored_len;
    logic        hdr_bad;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // reassembly prediction
    // ---------------------------------------------------------------

    function automatic result_t payload_beat(input logic [7:0] b, input logic [10:0] off);
        result_t r;
        r             = '0;
        r.kind        = KIND_PAYLOAD;
        r.byte_value  = b;
        r.byte_offset = off[OFFSET_W-1:0];
        return r;
    endfunction

    // status beat built from the current header and stored count
    function automatic result_t status_beat(input status_t s);
        result_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = s;
        if (s == STAT_COMPLETE)
        begin
            r.command      = cmd_word;
            r.sequence_res = seq_word;
        end
        if (s != STAT_HDR_ERR)
            r.message_len = stored_len;
        return r;
    endfunction

    // done once header plus stored payload reach the declared length
    function automatic logic message_done();
        return !((int'(stored_len) + HEADER_BYTES) < int'(decl_len));
    endfunction

    // one link byte in, zero to two result beats queued
    task automatic reassemble_byte(input logic [7:0] b, input logic fin);
        result_t    step_out[$];
        logic [3:0] pos;
        if (!in_message)
        begin
            pos = hdr_pos;
            case (pos)
                POS_MAGIC0:
                begin
                    hdr_bad    = (b != MAGIC0);
                    stored_len = '0;
                end
                POS_MAGIC1: if (b != MAGIC1) hdr_bad = 1'b1;
                POS_LEN_HI: decl_len = {b, 8'h00};
                POS_LEN_LO:
                begin
                    decl_len = {decl_len[15:8], b};
                    if (decl_len > MAX_PACKAGE)
                        decl_len = 16'(MAX_PACKAGE);
                end
                POS_CMD_HI: cmd_word = {b, 8'h00};
                POS_CMD_LO: cmd_word = {cmd_word[15:8], b};
                POS_SEQ_HI: seq_word = {b, 8'h00};
                POS_SEQ_LO: seq_word = {seq_word[15:8], b};
                default:
                begin
                    // first fragment payload only stops at the payload cap
                    if (!hdr_bad && stored_len < MAX_PAYLOAD)
                    begin
                        step_out.push_back(payload_beat(b, stored_len));
                        stored_len = stored_len + 1'b1;
                    end
                end
            endcase
            if (hdr_pos < HEADER_BYTES)
                hdr_pos = hdr_pos + 1'b1;
            if (fin)
            begin
                // bad magic or a fragment that ends inside the header
                if (hdr_bad || int'(pos) + 1 < HEADER_BYTES)
                    step_out.push_back(status_beat(STAT_HDR_ERR));
                else if (message_done())
                    step_out.push_back(status_beat(STAT_COMPLETE));
                else
                begin
                    in_message = 1'b1;
                    step_out.push_back(status_beat(STAT_INCOMPLETE));
                end
                hdr_pos = '0;
                hdr_bad = 1'b0;
            end
        end
        else
        begin
            // continuation: bytes past the declared length are dropped
            if (!message_done() && stored_len < MAX_PAYLOAD)
            begin
                step_out.push_back(payload_beat(b, stored_len));
                stored_len = stored_len + 1'b1;
            end
            if (fin)
            begin
                if (message_done())
                begin
                    in_message = 1'b0;
                    step_out.push_back(status_beat(STAT_COMPLETE));
                end
                else
                    step_out.push_back(status_beat(STAT_INCOMPLETE));
                hdr_pos = '0;
                hdr_bad = 1'b0;
            end
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            reassembly_out.push_back(step_out[i]);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // ---------------------------------------------------------------
    // input beat driver: offers queued bytes, holds a beat until taken
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : frag_driver
        link_byte_t nxt;
        if (!rst_n)
        begin
            frag_bus.valid <= 1'b0;
        end
        else
        begin
            // beat taken at this edge: predict what it causes
            if (frag_bus.valid && frag_bus.ready)
                reassemble_byte(frag_bus.data_byte, frag_bus.frag_last);
            if (!frag_bus.valid || frag_bus.ready)
            begin
                if (link_bytes.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    nxt = link_bytes.pop_front();
                    frag_bus.valid     <= 1'b1;
                    frag_bus.data_byte <= nxt.data;
                    frag_bus.frag_last <= nxt.fin;
                end
                else
                    frag_bus.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: compares each taken beat, drives res ready
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : res_monitor
        result_t want;
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (reassembly_out.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat expected none actual kind %0h status %0h",
                             $time, res_bus.kind, res_bus.status);
                end
                else
                begin
                    want = reassembly_out.pop_front();
                    check_field("kind", want.kind, res_bus.kind);
                    check_field("byte_value", want.byte_value, res_bus.byte_value);
                    check_field("byte_offset", want.byte_offset, res_bus.byte_offset);
                    check_field("status", want.status, res_bus.status);
                    check_field("command", want.command, res_bus.command);
                    check_field("sequence_res", want.sequence_res, res_bus.sequence_res);
                    check_field("message_len", want.message_len, res_bus.message_len);
                    check_field("last", want.last, res_bus.last);
                end
            end
            // one long stall while the sender keeps offering, else random idling
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (hold_armed && frag_bus.valid)
            begin
                hold_armed = 1'b0;
                hold_left  = LONG_HOLD;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : run_guard
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b, input logic fin);
        link_byte_t x;
        x.data = b;
        x.fin  = fin;
        link_bytes.push_back(x);
        queued_count++;
    endtask

    task automatic put_header(input logic [15:0] len, input logic [15:0] cmd,
                              input logic [15:0] seq, input logic fin);
        put_byte(MAGIC0, 1'b0);
        put_byte(MAGIC1, 1'b0);
        put_byte(len[15:8], 1'b0);
        put_byte(len[7:0], 1'b0);
        put_byte(cmd[15:8], 1'b0);
        put_byte(cmd[7:0], 1'b0);
        put_byte(seq[15:8], 1'b0);
        put_byte(seq[7:0], fin);
    endtask

    // random bytes, fragment end on the last one when fin is set
    task automatic put_run(input int count, input logic fin);
        for (int i = 0; i < count; i++)
            put_byte(8'($urandom), fin && (i == count - 1));
    endtask

    task automatic wait_drain();
        while (link_bytes.size() > 0 || frag_bus.valid || reassembly_out.size() > 0)
            @(negedge clk);
    endtask

    // mostly well-formed messages split at random, plus broken headers and noise
    task automatic run_phase(input int send_pct, input int recv_pct, input int items);
        int         stop_at;
        int         pick;
        int         decl;
        int         need;
        int         first;
        int         left;
        int         chunk;
        int         n;
        logic [7:0] b0;
        logic [7:0] b1;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = queued_count + items;
        while (queued_count < stop_at)
        begin
            pick = $urandom_range(19, 0);
            if (pick < 14)
            begin
                // declared length: sometimes under the header, now and then long
                n = $urandom_range(15, 0);
                if (n < 2)
                    decl = $urandom_range(HEADER_BYTES - 1, 0);
                else if (n == 2)
                    decl = $urandom_range(200, HEADER_BYTES);
                else
                    decl = $urandom_range(40, HEADER_BYTES);
                need  = (decl < HEADER_BYTES) ? 0 : decl - HEADER_BYTES;
                // first fragment may overshoot, it is not truncated
                first = $urandom_range(need + 3, 0);
                put_header(16'(decl), 16'($urandom), 16'($urandom), first == 0);
                put_run(first, 1'b1);
                left = need - first;
                while (left > 0)
                begin
                    // later fragments may run past the end and get cut
                    chunk = $urandom_range((left > 16) ? 16 : left + 2, 1);
                    put_run(chunk, 1'b1);
                    left -= chunk;
                end
            end
            else if (pick < 16)
            begin
                // bad magic in either byte, then one to twenty random bytes
                b0 = MAGIC0;
                b1 = MAGIC1;
                if ($urandom_range(1, 0))
                begin
                    b0 = 8'($urandom);
                    if (b0 == MAGIC0)
                        b0 = ~b0;
                end
                else
                begin
                    b1 = 8'($urandom);
                    if (b1 == MAGIC1)
                        b1 = ~b1;
                end
                put_byte(b0, 1'b0);
                put_byte(b1, 1'b0);
                put_run($urandom_range(20, 1), 1'b1);
            end
            else if (pick < 17)
            begin
                // good magic, fragment ends inside the header
                n = $urandom_range(HEADER_BYTES - 1, 1);
                put_byte(MAGIC0, n == 1);
                if (n > 1)
                    put_byte(MAGIC1, n == 2);
                put_run(n - 2, 1'b1);
            end
            else
            begin
                // plain noise, random fragment ends
                n = $urandom_range(10, 1);
                for (int i = 0; i < n; i++)
                    put_byte(8'($urandom), (i == n - 1) || ($urandom_range(3, 0) == 0));
            end
        end
        wait_drain();
    endtask

    // ---------------------------------------------------------------
    // sequence of the run
    // ---------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        frag_bus.valid     = 1'b0;
        frag_bus.data_byte = '0;
        frag_bus.frag_last = 1'b0;
        res_bus.ready      = 1'b0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        mismatches         = 0;
        cycle_count        = 0;
        queued_count       = 0;
        hold_left          = 0;
        hold_armed         = 1'b0;
        in_message         = 1'b0;
        hdr_pos            = '0;
        decl_len           = '0;
        cmd_word           = '0;
        seq_word           = '0;
        stored_len         = '0;
        hdr_bad            = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // declared length under the header size, payload still kept
        put_header(16'h0003, 16'hFFFF, 16'h0000, 1'b0);
        put_byte(8'h5A, 1'b1);
        // header alone leaves the message open, next fragment overshoots by one
        put_header(16'h000B, 16'h0000, 16'hFFFF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hC3, 1'b0);
        put_byte(8'h3C, 1'b1);
        // one-byte fragment
        put_byte(MAGIC0, 1'b1);
        // wrong second magic byte, bytes past the header are not payload
        put_byte(MAGIC0, 1'b0);
        put_byte(8'h00, 1'b0);
        put_run(7, 1'b1);
        wait_drain();

        run_phase(33, 77, 280);
        run_phase(77, 33, 280);

        // no idling, one long receiver stall early in this phase
        hold_armed = 1'b1;
        run_phase(0, 0, 290);

        repeat (8) @(negedge clk);
        if (mismatches == 0 && reassembly_out.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
